@@ hw/rtl/bfm3_pkg.sv @@
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants, command and status structs and a hash helper function.
// ----------------------------------------------------------------------------
package bfm3_pkg;

  localparam int unsigned TABLE_BITS = 65536;
  localparam int unsigned MAX_HASHES = 8;
  localparam int unsigned ADDR_W = (TABLE_BITS > 1) ? $clog2(TABLE_BITS) : 1;
  localparam int unsigned LANE_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_HASHES + 1);

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N = 32'he6546b64;
  localparam logic [31:0] FM_C1 = 32'h85ebca6b;
  localparam logic [31:0] FM_C2 = 32'hc2b2ae35;

  localparam logic [0:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [0:0] CFG_HASH_COUNT = 1'd1;
  localparam logic [0:0] REQ_INSERT = 1'b0;
  localparam logic [0:0] REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       absorb;    // Take one key byte into the block.
    logic       fin_start; // Begin finalizing the key.
    logic       clear_key; // Return hashing state to reset.
    logic       clr_start; // Begin store clearing.
    logic       probe_wr;  // Set the probed bit.
  } bfm3_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       clr_done;
    logic       bit_val;
  } bfm3_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ hw/rtl/bfm3_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfm3_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

@@ hw/rtl/bfm3_datapath.sv @@
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Murmur lanes, one shared finalizer, a restoring divider and the bit store.
// ----------------------------------------------------------------------------
module bfm3_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfm3_pkg::bfm3_cmd_t  cmd,
  output bfm3_pkg::bfm3_sts_t  sts,
  input  logic [7:0]           key_byte,
  input  logic [16:0]          table_size,
  input  logic [bfm3_pkg::LANE_W-1:0] lane
);
  import bfm3_pkg::*;

  logic [31:0] acc_r [MAX_HASHES];
  logic [31:0] acc_nxt [MAX_HASHES];
  logic [23:0] buf_r, buf_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [31:0] len_r, len_nxt;

  // Block scramble pipeline: multiply, rotate and multiply, then mix into every lane.
  logic [31:0] blk_k;
  logic [31:0] k1_r, k1_nxt, k2_r, k2_nxt, k3_r, k3_nxt;
  logic [1:0]  kph_r, kph_nxt;
  logic        kpend_r, kpend_nxt;

  // Finalizer and divider.
  logic [3:0]  fph_r, fph_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] tail_k_r, tail_k_nxt;
  logic [16:0] m_r, m_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        dbusy_r, dbusy_nxt, ddone_r, ddone_nxt;
  logic [17:0] trial;

  // Clearing sweep.
  logic [ADDR_W:0] clr_r, clr_nxt;
  logic            clr_busy_r, clr_busy_nxt;

  logic              ram_we, ram_wd, ram_rd;
  logic [ADDR_W-1:0] ram_addr;

  assign blk_k = {key_byte, buf_r};

  always_comb begin
    for (int i = 0; i < MAX_HASHES; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    buf_nxt = buf_r;
    fill_nxt = fill_r;
    len_nxt = len_r;
    k1_nxt = k1_r;
    k2_nxt = k2_r;
    k3_nxt = k3_r;
    kph_nxt = kph_r;
    kpend_nxt = kpend_r;
    if (cmd.absorb) begin
      len_nxt = len_r + 32'd1;
      if (fill_r == 2'd3) begin
        k1_nxt = blk_k * MM_C1;
        kph_nxt = 2'd1;
        kpend_nxt = 1'b1;
        buf_nxt = '0;
        fill_nxt = 2'd0;
      end else begin
        buf_nxt = buf_r | (24'(key_byte) << (5'(fill_r) * 5'd8));
        fill_nxt = fill_r + 2'd1;
      end
    end else if (kpend_r) begin
      case (kph_r)
        2'd1: begin
          k2_nxt = rotl32(k1_r, 15) * MM_C2;
          kph_nxt = 2'd2;
        end
        2'd2: begin
          for (int i = 0; i < MAX_HASHES; i++) begin
            acc_nxt[i] = rotl32(acc_r[i] ^ k2_r, 13) * 32'd5 + MM_N;
          end
          kpend_nxt = 1'b0;
          kph_nxt = 2'd0;
        end
        default: kph_nxt = 2'd0;
      endcase
    end
    if (cmd.clear_key) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        acc_nxt[i] = 32'(i);
      end
      buf_nxt = '0;
      fill_nxt = '0;
      len_nxt = '0;
    end
    k3_nxt = 32'(buf_r) * MM_C1;
  end

  always_comb begin
    fph_nxt = fph_r;
    h_nxt = h_r;
    tail_k_nxt = tail_k_r;
    m_nxt = m_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    dbusy_nxt = dbusy_r;
    ddone_nxt = 1'b0;
    trial = {rem_r, quo_r[31]} - {1'b0, m_r};
    if (cmd.fin_start) begin
      fph_nxt = 4'd1;
      h_nxt = acc_r[lane];
      m_nxt = (table_size == 17'd0) ? 17'd1 :
              (table_size > 17'(TABLE_BITS)) ? 17'(TABLE_BITS) : table_size;
    end else if (fph_r != 4'd0) begin
      fph_nxt = fph_r + 4'd1;
      case (fph_r)
        4'd1: tail_k_nxt = rotl32(k3_r, 15);
        4'd2: tail_k_nxt = tail_k_r * MM_C2;
        4'd3: begin
          h_nxt = ((fill_r != 2'd0) ? (h_r ^ tail_k_r) : h_r) ^ len_r;
          h_nxt = h_nxt ^ (h_nxt >> 16);
        end
        4'd4: h_nxt = h_r * FM_C1;
        4'd5: begin
          h_nxt = h_r ^ (h_r >> 13);
        end
        4'd6: h_nxt = h_r * FM_C2;
        4'd7: begin
          h_nxt = h_r ^ (h_r >> 16);
        end
        4'd8: begin
          rem_nxt = '0;
          quo_nxt = h_r;
          dcnt_nxt = 6'd32;
          dbusy_nxt = 1'b1;
          fph_nxt = 4'd0;
        end
        default: fph_nxt = 4'd0;
      endcase
    end else if (dbusy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[31]};
      end
      quo_nxt = {quo_r[30:0], 1'b0};
      dcnt_nxt = dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) begin
        dbusy_nxt = 1'b0;
        ddone_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    clr_nxt = clr_r;
    clr_busy_nxt = clr_busy_r;
    if (cmd.clr_start) begin
      clr_nxt = '0;
      clr_busy_nxt = 1'b1;
    end else if (clr_busy_r) begin
      clr_nxt = clr_r + 1'b1;
      if (clr_r == (ADDR_W+1)'(TABLE_BITS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_HASHES; i++) begin
        acc_r[i] <= 32'(i);
      end
      buf_r <= '0;
      fill_r <= '0;
      len_r <= '0;
      kph_r <= '0;
      kpend_r <= 1'b0;
      fph_r <= '0;
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      clr_busy_r <= 1'b0;
      clr_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      buf_r <= buf_nxt;
      fill_r <= fill_nxt;
      len_r <= len_nxt;
      kph_r <= kph_nxt;
      kpend_r <= kpend_nxt;
      fph_r <= fph_nxt;
      dbusy_r <= dbusy_nxt;
      ddone_r <= ddone_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_r <= clr_nxt;
    end
    k1_r <= k1_nxt;
    k2_r <= k2_nxt;
    k3_r <= k3_nxt;
    h_r <= h_nxt;
    tail_k_r <= tail_k_nxt;
    m_r <= m_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
  end

  assign ram_we = clr_busy_r | cmd.probe_wr;
  assign ram_wd = ~clr_busy_r;
  assign ram_addr = clr_busy_r ? clr_r[ADDR_W-1:0] : rem_r[ADDR_W-1:0];

  bfm3_ram #(.WIDTH(1), .DEPTH(TABLE_BITS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  assign sts.div_done = ddone_r;
  assign sts.clr_done = ~clr_busy_r & ~cmd.clr_start;
  assign sts.bit_val = ram_rd;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_key |=> (fill_r == 2'd0 && len_r == 32'd0))
    else $error("key state not cleared");
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    ddone_r |-> !dbusy_r)
    else $error("divider done while busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !cmd.probe_wr)
    else $error("probe during clear");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ddone_r |-> (rem_r < m_r))
    else $error("remainder out of range");
`endif
endmodule

@@ hw/rtl/bfm3_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences byte absorption, per-lane finalize and probes, and the result.
// ----------------------------------------------------------------------------
module bfm3_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic                 in_has_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_present,
  input  logic [3:0]           hash_count,
  output bfm3_pkg::bfm3_cmd_t  cmd,
  input  bfm3_pkg::bfm3_sts_t  sts,
  output logic [bfm3_pkg::LANE_W-1:0] lane
);
  import bfm3_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MIX, S_FIN, S_PROBE, S_CHECK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]       mix_r, mix_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic             req_r, req_nxt, all_r, all_nxt;
  logic             ov_r, ov_nxt, op_r, op_nxt;
  logic             acc;
  logic             in_last_r;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || (ov_r && out_stall);
  assign lane = cnt_nxt[LANE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    mix_nxt = mix_r;
    cnt_nxt = cnt_r;
    n_nxt = n_r;
    req_nxt = req_r;
    all_nxt = all_r;
    ov_nxt = ov_r;
    op_nxt = op_r;
    cmd = '0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          cmd.absorb = in_has_byte;
          req_nxt = in_req_type;
          mix_nxt = 2'd0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        mix_nxt = mix_r + 2'd1;
        if (mix_r == 2'd2) begin
          if (!in_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = '0;
            n_nxt = (hash_count > 4'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : CNT_W'(hash_count);
            all_nxt = 1'b1;
            if (hash_count == 4'd0) begin
              state_nxt = S_DONE;
            end else begin
              cmd.fin_start = 1'b1;
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (sts.div_done) begin
          if (req_r == REQ_INSERT) begin
            cmd.probe_wr = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r == REQ_QUERY && !sts.bit_val) begin
          all_nxt = 1'b0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r + 1'b1 == n_r) begin
          state_nxt = S_DONE;
        end else begin
          cmd.fin_start = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DONE: begin
        if (req_r == REQ_QUERY) begin
          if (!ov_nxt) begin
            ov_nxt = 1'b1;
            op_nxt = all_r;
            cmd.clear_key = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.clear_key = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
    mix_r <= mix_nxt;
    cnt_r <= cnt_nxt;
    n_r <= n_nxt;
    req_r <= req_nxt;
    all_r <= all_nxt;
    op_r <= op_nxt;
    if (acc) begin
      in_last_r <= in_last;
    end
  end

  assign out_valid = ov_r;
  assign out_present = op_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (cnt_r < n_r))
    else $error("probe count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_present)))
    else $error("stalled beat changed");
`endif
endmodule

@@ hw/rtl/bloom_filter_murmur3.sv @@
// Timing: a byte beat passes through the mix states; the key-end beat adds,
// per hash lane, the finalize pipeline, a 32-step divider and a store access.
// No beat is taken until the last is through, nor while a stalled result is
// held; the divider sets the key-end cost. After reset the bit store is swept
// clear (65536 addresses), taking no beat; configuration resets to 65536, 3.
// ----------------------------------------------------------------------------
// Bloom filter top level
// MurmurHash3 x86_32 Bloom filter with a byte-serial key input.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_key_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_present,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import bfm3_pkg::*;

  logic [16:0] tsize_r;
  logic [3:0]  hcnt_r;
  logic        clr_pend_r;
  bfm3_cmd_t   cmd, cmd_c;
  bfm3_sts_t   sts;
  logic [LANE_W-1:0] lane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= 17'd65536;
      hcnt_r <= 4'd3;
      clr_pend_r <= 1'b1;
    end else begin
      clr_pend_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SIZE: tsize_r <= cfg_wdata;
          CFG_HASH_COUNT: hcnt_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cmd = cmd_c;
    cmd.clr_start = clr_pend_r;
  end

  bfm3_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_has_byte (in_has_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_present (out_present),
    .hash_count  (hcnt_r),
    .cmd         (cmd_c),
    .sts         (sts),
    .lane        (lane)
  );

  bfm3_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .key_byte   (in_key_byte),
    .table_size (tsize_r),
    .lane       (lane)
  );
endmodule

@@ tb/sv/bloom_filter_murmur3_tb.sv @@
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Streams keys byte by byte into the filter, predicts every query answer
// with a local MurmurHash3 model and bit store, and checks each result beat.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3_tb;
  import bfm3_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_key_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic        out_present;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_wdata;

  bloom_filter_murmur3 u_dut (.*);

  bit          filt_bits [TABLE_BITS];
  logic [31:0] lane_acc [MAX_HASHES];
  logic [23:0] blk_buf;
  int unsigned blk_fill;
  logic [31:0] key_len;
  logic [16:0] tsize;
  logic [3:0]  hcount;
  bit          answer_q[$];
  int          err_cnt;
  int          send_idle;
  int          recv_stall;
  logic [7:0]  word_pool [4][];

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] mm_scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * MM_C1;
    t = (t << 15) | (t >> 17);
    return t * MM_C2;
  endfunction

  function automatic logic [31:0] mm_fmix(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FM_C1;
    t = t ^ (t >> 13);
    t = t * FM_C2;
    return t ^ (t >> 16);
  endfunction

  function automatic void key_reset();
    for (int i = 0; i < MAX_HASHES; i++) lane_acc[i] = i;
    blk_buf = '0;
    blk_fill = 0;
    key_len = '0;
  endfunction

  function automatic void predict_beat(input logic req, input logic [7:0] b,
                                       input logic has, input logic lst);
    logic [31:0] k;
    logic [31:0] h;
    int unsigned m;
    int unsigned n;
    int unsigned idx;
    bit all_set;
    all_set = 1'b1;
    if (has) begin
      if (blk_fill == 3) begin
        k = mm_scramble({b, blk_buf});
        for (int i = 0; i < MAX_HASHES; i++) begin
          h = lane_acc[i] ^ k;
          h = (h << 13) | (h >> 19);
          lane_acc[i] = h * 5 + MM_N;
        end
        blk_buf = '0;
        blk_fill = 0;
      end else begin
        blk_buf = blk_buf | (24'(b) << (8 * blk_fill));
        blk_fill++;
      end
      key_len++;
    end
    if (!lst) return;
    m = (tsize == 0) ? 1 : tsize;
    if (m > TABLE_BITS) m = TABLE_BITS;
    n = (hcount > MAX_HASHES) ? MAX_HASHES : hcount;
    for (int i = 0; i < n; i++) begin
      h = lane_acc[i];
      if (blk_fill != 0) h = h ^ mm_scramble({8'h00, blk_buf});
      h = mm_fmix(h ^ key_len);
      idx = h % m;
      if (req == REQ_INSERT) filt_bits[idx] = 1'b1;
      else if (!filt_bits[idx]) all_set = 1'b0;
    end
    key_reset();
    if (req == REQ_QUERY) answer_q.push_back(all_set);
  endfunction

  task automatic send_beat(input logic req, input logic [7:0] b,
                           input logic has, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_key_byte <= b;
    in_has_byte <= has;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(req, b, has, lst);
  endtask

  task automatic send_word(input logic req, input logic [7:0] bytes[]);
    bit bare_end;
    bare_end = (bytes.size() == 0) || $urandom_range(1);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(15) == 0)
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(bare_end ? 1'($urandom_range(1)) : req, bytes[i], 1'b1,
                !bare_end && i == bytes.size() - 1);
    end
    if (bare_end) send_beat(req, 8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TABLE_SIZE) tsize = val;
    else hcount = val[3:0];
    @(posedge clk);
  endtask

  task automatic random_bytes(output logic [7:0] bytes[], input int maxlen);
    bytes = new[$urandom_range(maxlen)];
    foreach (bytes[i]) bytes[i] = 8'($urandom_range(255));
  endtask

  task automatic test_directed();
    logic [7:0] bytes[];
    bytes = new[0];
    send_word(REQ_QUERY, bytes);
    send_word(REQ_INSERT, bytes);
    send_word(REQ_QUERY, bytes);
    bytes = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01};
    send_word(REQ_QUERY, bytes);
    send_word(REQ_INSERT, bytes);
    send_word(REQ_QUERY, bytes);
    send_beat(REQ_QUERY, 8'hff, 1'b0, 1'b0);
    bytes = '{8'h80, 8'h7f, 8'hfe};
    send_word(REQ_INSERT, bytes);
    send_word(REQ_QUERY, bytes);
    drain();
  endtask

  task automatic test_config_extremes();
    logic [7:0] bytes[];
    logic [16:0] sizes[6];
    logic [3:0] counts[6];
    sizes = '{17'd1, 17'd0, 17'h1ffff, 17'd65536, 17'd17, 17'd300};
    counts = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd5};
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_TABLE_SIZE, sizes[p]);
      write_cfg(CFG_HASH_COUNT, {13'd0, counts[p]});
      for (int j = 0; j < 6; j++) begin
        random_bytes(bytes, 6);
        send_word(1'($urandom_range(1)), bytes);
        send_word(REQ_QUERY, bytes);
      end
      drain();
    end
  endtask

  task automatic test_random(input int beats, input int sidle, input int rstall);
    logic [7:0] bytes[];
    int sent;
    send_idle = sidle;
    recv_stall = rstall;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(3) == 0) bytes = word_pool[$urandom_range(3)];
      else random_bytes(bytes, 9);
      send_word(1'($urandom_range(1)), bytes);
      sent += bytes.size() + 1;
      if ($urandom_range(30) == 0) begin
        drain();
        write_cfg(CFG_TABLE_SIZE, 17'($urandom_range(1, 2000)));
        write_cfg(CFG_HASH_COUNT, 17'($urandom_range(0, 9)));
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result beat: present=%0b", out_present);
        end else begin
          if (out_present !== answer_q[0]) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("present mismatch: expected %0b actual %0b", answer_q[0], out_present);
          end
          void'(answer_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_key_byte = '0;
    in_has_byte = 1'b0;
    in_last = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_cnt = 0;
    send_idle = 0;
    recv_stall = 0;
    tsize = 17'd65536;
    hcount = 4'd3;
    key_reset();
    for (int i = 0; i < 4; i++) begin
      word_pool[i] = new[i * 2 + 1];
      foreach (word_pool[i][j]) word_pool[i][j] = 8'($urandom_range(255));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    write_cfg(CFG_TABLE_SIZE, 17'd512);
    write_cfg(CFG_HASH_COUNT, 17'd4);
    test_random(150, 0, 0);
    test_random(125, 86, 0);
    test_random(125, 0, 86);
    test_random(150, 34, 34);
    if (err_cnt == 0) begin
      $display("PASS bloom_filter_murmur3");
    end else begin
      $display("FAIL bloom_filter_murmur3");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL bloom_filter_murmur3");
    $finish;
  end

endmodule
